>>> design/whp_pkg.sv
// shared types and constants for the wav header parser
package whp_pkg;

   localparam logic [31:0] ID_RIFF = 32'h4646_4952;
   localparam logic [31:0] ID_WAVE = 32'h4556_4157;
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;

   localparam logic [15:0] LIMIT_RESET   = 16'd4096;
   localparam logic [33:0] FMT_CHUNK_POS = 34'd12;
   localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;
   localparam logic [33:0] POS_MAX       = 34'h0_FFFF_FFF7;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED   = 2'd2;

   localparam logic [32:0] POS_RIFF_END      = 33'd3;
   localparam logic [32:0] POS_WAVE_END      = 33'd11;
   localparam logic [32:0] POS_FMT_ID_END    = 33'd15;
   localparam logic [32:0] POS_FMT_SIZE_END  = 33'd19;
   localparam logic [32:0] POS_FORMAT_END    = 33'd21;
   localparam logic [32:0] POS_CHANNELS_END  = 33'd23;
   localparam logic [32:0] POS_RATE_END      = 33'd27;
   localparam logic [32:0] POS_BYTE_RATE_END = 33'd31;
   localparam logic [32:0] POS_ALIGN_END     = 33'd33;
   localparam logic [32:0] POS_WIDTH_END     = 33'd35;

   localparam logic [32:0] CHUNK_ID_END   = 33'd3;
   localparam logic [32:0] CHUNK_SIZE_END = 33'd7;
   localparam logic [33:0] CHUNK_HDR_LEN  = 34'd8;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic REG_SEARCH_LIMIT = 1'b0;

   localparam int RSP_TDATA_WIDTH = 168;
   localparam int RSP_BIT_RATE_LSB = 64;
   localparam int RSP_OFFSET_LSB = 131;
   localparam logic [31:0] MIN_DATA_OFFSET = 32'd44;

   typedef struct packed {
      logic [31:0] word;
      logic [32:0] pos;
      logic        start;
      logic        last;
   } item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] audio_format;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [34:0] bit_rate;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
      logic [31:0] data_offset;
   } result_type;

endpackage

>>> design/whp_front.sv
// front end: takes byte transfers, tracks file offset and the last four bytes
module whp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tuser,
   input  logic                req_tlast,
   output logic                push_valid,
   output whp_pkg::item_type   push_item,
   input  logic                push_ready
);

   logic [31:0] shift_ff;
   logic [31:0] shift_in;
   logic [32:0] pos_ff;
   logic [32:0] pos_cur;
   logic        accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   assign pos_cur  = req_tuser ? 33'd0 : pos_ff;
   assign shift_in = {req_tdata, shift_ff[31:8]};

   always_comb begin
      push_item.word  = shift_in;
      push_item.pos   = pos_cur;
      push_item.start = req_tuser;
      push_item.last  = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         shift_ff <= '0;
      end else if (accept) begin
         pos_ff   <= pos_cur + 33'd1;
         shift_ff <= shift_in;
      end
   end

endmodule

>>> design/whp_queue.sv
// short queue of classified bytes between front and back
module whp_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  whp_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output whp_pkg::item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   whp_pkg::item_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic push;
   logic pop;

   assign push_ready = count_ff < CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

>>> design/whp_back.sv
// back end: header checks, fmt capture, chunk walk and the result register
module whp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          search_limit,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  whp_pkg::item_type    pop_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output whp_pkg::result_type  rsp_result
);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_SEARCH = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   logic [1:0]  phase_ff, phase_in, phase_cur;
   logic [31:0] next_ff, next_in;
   logic [15:0] format_ff, format_in;
   logic [15:0] channels_ff, channels_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] byte_rate_ff, byte_rate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] width_ff, width_in;

   logic                rsp_valid_ff;
   whp_pkg::result_type rsp_result_ff, rsp_result_in;

   logic        take;
   logic        active;
   logic        have;
   logic        emit;
   logic [1:0]  status;
   logic [31:0] offset;
   logic [31:0] word;
   logic [33:0] n_hdr;
   logic [33:0] n_search;
   logic [32:0] off;
   logic        in_chunk;
   logic        ok;

   assign pop_ready  = !rsp_valid_ff || rsp_ready;
   assign take       = pop_valid && pop_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   assign word      = pop_item.word;
   assign phase_cur = pop_item.start ? PH_HEADER : phase_ff;
   assign active    = (phase_cur == PH_HEADER) || (phase_cur == PH_SEARCH);
   assign n_hdr     = whp_pkg::FMT_CHUNK_POS + whp_pkg::CHUNK_HDR_LEN + {2'b00, word}
                      + {33'd0, word[0]};
   assign n_search  = {2'b00, next_ff} + whp_pkg::CHUNK_HDR_LEN + {2'b00, word}
                      + {33'd0, word[0]};
   assign in_chunk  = pop_item.pos >= {1'b0, next_ff};
   assign off       = pop_item.pos - {1'b0, next_ff};

   always_comb begin
      have         = 1'b0;
      status       = whp_pkg::STATUS_OK;
      offset       = '0;
      next_in      = next_ff;
      phase_in     = phase_cur;
      format_in    = format_ff;
      channels_in  = channels_ff;
      rate_in      = rate_ff;
      byte_rate_in = byte_rate_ff;
      align_in     = align_ff;
      width_in     = width_ff;
      unique case (phase_cur)
         PH_HEADER: begin
            unique case (pop_item.pos)
               whp_pkg::POS_RIFF_END: begin
                  if (word != whp_pkg::ID_RIFF) begin
                     have   = 1'b1;
                     status = whp_pkg::STATUS_UNSUPPORTED;
                  end
               end
               whp_pkg::POS_WAVE_END: begin
                  if (word != whp_pkg::ID_WAVE) begin
                     have   = 1'b1;
                     status = whp_pkg::STATUS_UNSUPPORTED;
                  end
               end
               whp_pkg::POS_FMT_ID_END: begin
                  if (word != whp_pkg::ID_FMT) begin
                     have   = 1'b1;
                     status = whp_pkg::STATUS_UNSUPPORTED;
                  end
               end
               whp_pkg::POS_FMT_SIZE_END: begin
                  if (word < whp_pkg::FMT_MIN_SIZE || n_hdr > whp_pkg::POS_MAX) begin
                     have   = 1'b1;
                     status = whp_pkg::STATUS_UNSUPPORTED;
                  end else begin
                     next_in = n_hdr[31:0];
                  end
               end
               whp_pkg::POS_FORMAT_END:    format_in    = word[31:16];
               whp_pkg::POS_CHANNELS_END:  channels_in  = word[31:16];
               whp_pkg::POS_RATE_END:      rate_in      = word;
               whp_pkg::POS_BYTE_RATE_END: byte_rate_in = word;
               whp_pkg::POS_ALIGN_END:     align_in     = word[31:16];
               whp_pkg::POS_WIDTH_END: begin
                  width_in = word[31:16];
                  phase_in = PH_SEARCH;
               end
               default: begin
               end
            endcase
         end
         PH_SEARCH: begin
            if (in_chunk) begin
               if (off == whp_pkg::CHUNK_ID_END && word == whp_pkg::ID_DATA) begin
                  have   = 1'b1;
                  offset = next_ff + 32'd8;
               end else if (off == whp_pkg::CHUNK_SIZE_END) begin
                  if (n_search > {18'd0, search_limit}) begin
                     have   = 1'b1;
                     status = whp_pkg::STATUS_UNSUPPORTED;
                  end else begin
                     next_in = n_search[31:0];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (!have) begin
         status = whp_pkg::STATUS_TRUNCATED;
      end
      emit = active && (have || pop_item.last);
      if (emit) begin
         phase_in = PH_DONE;
      end
   end

   assign ok = status == whp_pkg::STATUS_OK;

   always_comb begin
      rsp_result_in.status          = status;
      rsp_result_in.audio_format    = ok ? format_ff : 16'd0;
      rsp_result_in.channel_count   = ok ? channels_ff : 16'd0;
      rsp_result_in.sample_rate     = ok ? rate_ff : 32'd0;
      rsp_result_in.bit_rate        = ok ? {byte_rate_ff, 3'b000} : 35'd0;
      rsp_result_in.block_align     = ok ? align_ff : 16'd0;
      rsp_result_in.bits_per_sample = ok ? width_ff : 16'd0;
      rsp_result_in.data_offset     = ok ? offset : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in;
         end
         if (take && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         next_ff      <= next_in;
         format_ff    <= format_in;
         channels_ff  <= channels_in;
         rate_ff      <= rate_in;
         byte_rate_ff <= byte_rate_in;
         align_ff     <= align_in;
         width_ff     <= width_in;
      end
      if (take && emit) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

endmodule

>>> design/wav_header_parser.sv
// wav header parser top level: byte stream in, at most one header result per file out
//
//   channel  direction  payload
//   req      in         tdata: data_byte; tuser: file_start; tlast: file_end
//   rsp      out        tdata: fmt fields and data offset; tuser: status
//   csr      in/out     apb register search_limit at address 0
//
// one byte transfer per cycle unless a result waits on rsp
// the front is combinational; the queue and the result register are registered
// rsp_tvalid is registered: the byte that ends the result passes the queue, then sets the result register
// reset is synchronous; search_limit returns to 4096, no clearing pass
// a stalled rsp fills the queue, then req_tready drops until rsp is taken
module wav_header_parser #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // data_byte
   input  logic                                req_tuser,   // file_start
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // audio_format, channel_count, sample_rate, bit_rate, block_align,
   // bits_per_sample, data_offset, zero fill
   output logic [whp_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   output logic [1:0]                          rsp_tuser,   // status
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [whp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [15:0] limit_ff;
   logic        csr_write;

   logic              push_valid, push_ready;
   whp_pkg::item_type push_item;
   logic              pop_valid, pop_ready;
   whp_pkg::item_type pop_item;
   whp_pkg::result_type result;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == whp_pkg::REG_SEARCH_LIMIT) ? {16'd0, limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= whp_pkg::LIMIT_RESET;
      end else if (csr_write && csr_paddr[2] == whp_pkg::REG_SEARCH_LIMIT) begin
         limit_ff <= csr_pwdata[15:0];
      end
   end

   whp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   whp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   whp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .search_limit (limit_ff),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_item     (pop_item),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_result   (result)
   );

   assign rsp_tuser = result.status;
   assign rsp_tdata = {5'd0, result.data_offset, result.bits_per_sample, result.block_align,
                       result.bit_rate, result.sample_rate, result.channel_count,
                       result.audio_format};

endmodule

>>> design/whp_checker.sv
// port level checks for the wav header parser, bound to the top level
module whp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [whp_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic [1:0]                          rsp_tuser,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [whp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input logic [31:0]                         csr_pwdata,
   input logic [31:0]                         csr_prdata,
   input logic                                csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transfer changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != whp_pkg::STATUS_OK |-> rsp_tdata == '0)
      else $error("failed result carries field data");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == whp_pkg::STATUS_OK || rsp_tuser == whp_pkg::STATUS_UNSUPPORTED
                     || rsp_tuser == whp_pkg::STATUS_TRUNCATED)
      else $error("unknown status code");

   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == whp_pkg::STATUS_OK |->
         rsp_tdata[whp_pkg::RSP_BIT_RATE_LSB +: 3] == 3'd0 &&
         rsp_tdata[whp_pkg::RSP_OFFSET_LSB +: 32] >= whp_pkg::MIN_DATA_OFFSET)
      else $error("ok result with bad bit rate or data offset");

   a_limit_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
         && csr_paddr[2] == whp_pkg::REG_SEARCH_LIMIT |=>
         csr_paddr[2] != whp_pkg::REG_SEARCH_LIMIT
         || csr_prdata == {16'd0, $past(csr_pwdata[15:0])})
      else $error("search_limit readback mismatch");

endmodule

bind wav_header_parser whp_checker u_whp_checker (.*);

>>> tb/sv/wav_header_parser_test.sv
// self-checking testbench for the wav header parser: byte stream in, header results out
module wav_header_parser_test;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFF7;
   localparam int FMT_POS = 12;
   localparam int HDR_LEN = 8;
   localparam int MIN_FMT_SIZE = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [whp_pkg::CSR_ADDR_WIDTH-1:0] LIMIT_ADDR =
      {whp_pkg::REG_SEARCH_LIMIT, 2'b00};

   typedef struct packed {
      logic [7:0] data;
      logic       start;
      logic       last;
   } file_byte_type;

   typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} field_fill_type;
   typedef enum {READY_ALWAYS, READY_THREE_OF_FOUR, READY_COIN} stall_mode_type;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [7:0]                          req_tdata;
   logic                                req_tuser;
   logic                                req_tlast;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [whp_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic [1:0]                          rsp_tuser;
   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [whp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr;
   logic [31:0]                         csr_pwdata;
   logic [31:0]                         csr_prdata;
   logic                                csr_pready;

   class wave_header_scoreboard;
      typedef enum logic [1:0] {WAIT_START, IN_HEADER, IN_SEARCH, FINISHED} parse_phase_type;

      parse_phase_type      phase;
      logic [32:0]          position;
      logic [32:0]          chunk_position;
      logic [31:0]          shift_word;
      logic [15:0]          fmt_code;
      logic [15:0]          channels;
      logic [31:0]          rate;
      logic [31:0]          byte_rate;
      logic [15:0]          align;
      logic [15:0]          sample_bits;
      logic [15:0]          limit;
      whp_pkg::result_type  pending_headers[$];
      int                   errors;

      function new();
         limit = 16'd4096;
         phase = WAIT_START;
         errors = 0;
         clear();
      endfunction

      function void clear();
         position = '0;
         chunk_position = '0;
         shift_word = '0;
         fmt_code = '0;
         channels = '0;
         rate = '0;
         byte_rate = '0;
         align = '0;
         sample_bits = '0;
      endfunction

      function void set_limit(logic [15:0] value);
         limit = value;
      endfunction

      function void report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch in %s: got %0h, expected %0h", what, got, want);
         errors++;
      endfunction

      function void take_byte(logic [7:0] b, logic start, logic last);
         logic [32:0]         here;
         logic [32:0]         into_chunk;
         logic [63:0]         next_pos;
         logic                done;
         logic [1:0]          status;
         logic [32:0]         audio_start;
         whp_pkg::result_type header;
         done = 1'b0;
         status = whp_pkg::STATUS_OK;
         audio_start = '0;
         if (start) begin
            clear();
            phase = IN_HEADER;
         end
         if (phase == IN_HEADER || phase == IN_SEARCH) begin
            shift_word = {b, shift_word[31:8]};
            here = position;
            if (phase == IN_HEADER) begin
               // byte offsets where each header field completes
               case (here)
                  33'd3:  done = (shift_word != TAG_RIFF);
                  33'd11: done = (shift_word != TAG_WAVE);
                  33'd15: done = (shift_word != TAG_FMT);
                  33'd19: begin
                     next_pos = 64'(FMT_POS) + 64'(HDR_LEN) + 64'(shift_word)
                              + 64'(shift_word[0]);
                     if (shift_word < MIN_FMT_SIZE || next_pos > 64'(OFFSET_MAX)) done = 1'b1;
                     else chunk_position = next_pos[32:0];
                  end
                  33'd21: fmt_code = shift_word[31:16];
                  33'd23: channels = shift_word[31:16];
                  33'd27: rate = shift_word;
                  33'd31: byte_rate = shift_word;
                  33'd33: align = shift_word[31:16];
                  33'd35: begin
                     sample_bits = shift_word[31:16];
                     phase = IN_SEARCH;
                  end
                  default: ;
               endcase
               if (done) status = whp_pkg::STATUS_UNSUPPORTED;
            end else if (here >= chunk_position) begin
               into_chunk = here - chunk_position;
               if (into_chunk == 33'd3 && shift_word == TAG_DATA) begin
                  done = 1'b1;
                  audio_start = chunk_position + 33'(HDR_LEN);
               end else if (into_chunk == 33'd7) begin
                  next_pos = 64'(chunk_position) + 64'(HDR_LEN) + 64'(shift_word)
                           + 64'(shift_word[0]);
                  if (next_pos > 64'(limit)) begin
                     done = 1'b1;
                     status = whp_pkg::STATUS_UNSUPPORTED;
                  end else begin
                     chunk_position = next_pos[32:0];
                  end
               end
            end
            position = here + 33'd1;
            if (done || last) begin
               phase = FINISHED;
               header = '0;
               header.status = done ? status : whp_pkg::STATUS_TRUNCATED;
               if (header.status == whp_pkg::STATUS_OK) begin
                  header.audio_format = fmt_code;
                  header.channel_count = channels;
                  header.sample_rate = rate;
                  header.bit_rate = {byte_rate, 3'b000};
                  header.block_align = align;
                  header.bits_per_sample = sample_bits;
                  header.data_offset = audio_start[31:0];
               end
               pending_headers.push_back(header);
            end
         end
      endfunction

      function void check_result(logic [whp_pkg::RSP_TDATA_WIDTH-1:0] d, logic [1:0] st);
         whp_pkg::result_type want;
         if (pending_headers.size() == 0) begin
            report("result with nothing pending", 64'(st), 64'(0));
         end else begin
            want = pending_headers.pop_front();
            if (st != want.status) report("status", 64'(st), 64'(want.status));
            if (d[15:0] != want.audio_format)
               report("audio_format", 64'(d[15:0]), 64'(want.audio_format));
            if (d[31:16] != want.channel_count)
               report("channel_count", 64'(d[31:16]), 64'(want.channel_count));
            if (d[63:32] != want.sample_rate)
               report("sample_rate", 64'(d[63:32]), 64'(want.sample_rate));
            if (d[98:64] != want.bit_rate)
               report("bit_rate", 64'(d[98:64]), 64'(want.bit_rate));
            if (d[114:99] != want.block_align)
               report("block_align", 64'(d[114:99]), 64'(want.block_align));
            if (d[130:115] != want.bits_per_sample)
               report("bits_per_sample", 64'(d[130:115]), 64'(want.bits_per_sample));
            if (d[162:131] != want.data_offset)
               report("data_offset", 64'(d[162:131]), 64'(want.data_offset));
            if (d[167:163] != '0) report("tdata fill", 64'(d[167:163]), 64'(0));
         end
      endfunction
   endclass

   wave_header_scoreboard sb = new();

   file_byte_type stim_q[$];
   logic [7:0] file_buf[$];
   int         bytes_queued = 0;
   int         files_queued = 0;
   int         burst_left = 0;
   int         quiet_cycles = 0;
   bit         hold_rsp_request = 1'b0;

   wav_header_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void add_byte(logic [7:0] data, logic start, logic last);
      file_byte_type item;
      item.data = data;
      item.start = start;
      item.last = last;
      stim_q.push_back(item);
   endfunction

   function automatic void put_le(logic [31:0] value, int count);
      for (int i = 0; i < count; i++) file_buf.push_back(value[8*i +: 8]);
   endfunction

   function automatic void put_at(int idx, logic [31:0] value);
      for (int i = 0; i < 4; i++) file_buf[idx + i] = value[8*i +: 8];
   endfunction

   // riff header, fmt chunk, some other chunks, then a data chunk with a few audio bytes
   function automatic void make_wave(logic [31:0] fmt_size, int extras, field_fill_type fill);
      logic [31:0] chunk_size;
      int          body;
      file_buf.delete();
      put_le(TAG_RIFF, 4);
      put_le($urandom, 4);
      put_le(TAG_WAVE, 4);
      put_le(TAG_FMT, 4);
      put_le(fmt_size, 4);
      for (int i = 0; i < 16; i++)
         case (fill)
            FILL_ZERO: file_buf.push_back(8'h00);
            FILL_ONES: file_buf.push_back(8'hFF);
            default:   file_buf.push_back(8'($urandom));
         endcase
      body = (fmt_size >= 16 && fmt_size <= 64) ? int'(fmt_size) - 16 + int'(fmt_size[0]) : 0;
      repeat (body) file_buf.push_back(8'($urandom));
      repeat (extras) begin
         chunk_size = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5000)
                                                  : $urandom_range(0, 24);
         put_le($urandom, 4);
         put_le(chunk_size, 4);
         // long bodies are cut short, which puts the search out of step
         repeat ((chunk_size > 64 ? 64 : int'(chunk_size)) + int'(chunk_size[0]))
            file_buf.push_back(8'($urandom));
      end
      put_le(TAG_DATA, 4);
      put_le($urandom_range(0, 64), 4);
      repeat ($urandom_range(0, 6)) file_buf.push_back(8'($urandom));
   endfunction

   function automatic void emit_file(int count, bit with_end);
      if (count > file_buf.size()) count = file_buf.size();
      for (int i = 0; i < count; i++)
         add_byte(file_buf[i], i == 0, with_end && i == count - 1);
      bytes_queued += count;
      if (with_end) files_queued++;
   endfunction

   function automatic void run_directed();
      // stray bytes before any file
      add_byte(8'($urandom), 1'b0, 1'b0);
      add_byte(8'($urandom), 1'b0, 1'b1);
      add_byte(8'($urandom), 1'b0, 1'b0);
      make_wave(16, 0, FILL_ZERO);
      emit_file(file_buf.size(), 1);
      make_wave(16, 0, FILL_ONES);
      emit_file(file_buf.size(), 1);
      // file ends on the last byte of the data id
      make_wave(16, 0, FILL_RANDOM);
      emit_file(40, 1);
      make_wave(16, 0, FILL_RANDOM);
      file_buf[0] ^= 8'h01;
      emit_file(8, 1);
      make_wave(16, 0, FILL_RANDOM);
      file_buf[11] ^= 8'h80;
      emit_file(16, 1);
      make_wave(16, 0, FILL_RANDOM);
      file_buf[14] ^= 8'h20;
      emit_file(20, 1);
      make_wave(16, 0, FILL_RANDOM);
      put_at(16, 32'd15);
      emit_file(24, 1);
      put_at(16, 32'd0);
      emit_file(24, 1);
      make_wave(17, 1, FILL_RANDOM);
      emit_file(file_buf.size(), 1);
      // fmt size pushes the first chunk just past and just inside 32 bits
      make_wave(16, 0, FILL_RANDOM);
      put_at(16, 32'hFFFF_FFE3);
      emit_file(24, 1);
      put_at(16, 32'hFFFF_FFE2);
      emit_file(44, 1);
      // chunk ending exactly at the reset search limit, then just past it
      make_wave(16, 1, FILL_RANDOM);
      put_at(40, 32'd4052);
      emit_file(48, 1);
      put_at(40, 32'd4053);
      emit_file(48, 1);
      // near miss on the data id
      make_wave(16, 1, FILL_RANDOM);
      put_at(36, TAG_DATA ^ 32'h0600_0000);
      emit_file(file_buf.size(), 1);
      make_wave(16, 3, FILL_RANDOM);
      emit_file(file_buf.size(), 1);
      make_wave(16, 0, FILL_RANDOM);
      emit_file(30, 1);
      emit_file(38, 1);
      // restart in the middle of a file
      make_wave(16, 1, FILL_RANDOM);
      emit_file(25, 0);
      make_wave(20, 1, FILL_RANDOM);
      emit_file(file_buf.size(), 1);
      add_byte(8'($urandom), 1'b1, 1'b1);
   endfunction

   function automatic void random_files(int byte_goal, int file_goal);
      int bytes_at_start;
      int files_at_start;
      int kind;
      bytes_at_start = bytes_queued;
      files_at_start = files_queued;
      while (bytes_queued - bytes_at_start < byte_goal
             || files_queued - files_at_start < file_goal) begin
         kind = $urandom_range(0, 19);
         make_wave(($urandom_range(0, 3) == 0) ? $urandom_range(16, 40) : 16,
                   $urandom_range(0, 3), FILL_RANDOM);
         if (kind < 11) begin
            emit_file(file_buf.size(), 1);
         end else if (kind < 13) begin
            emit_file($urandom_range(1, file_buf.size()), 1);
         end else if (kind < 15) begin
            file_buf[$urandom_range(0, 19)] ^= 8'(1 << $urandom_range(0, 7));
            emit_file(file_buf.size(), 1);
         end else if (kind < 16) begin
            put_at(16, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(32'hFFFF_FFD0, 32'hFFFF_FFFF));
            emit_file(file_buf.size(), 1);
         end else if (kind < 18) begin
            emit_file($urandom_range(1, file_buf.size() - 1), 0);
         end else begin
            repeat ($urandom_range(1, 6))
               add_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endfunction

   task automatic send_all();
      file_byte_type item;
      while (stim_q.size() != 0) begin
         item = stim_q.pop_front();
         req_tvalid <= 1'b1;
         req_tdata <= item.data;
         req_tuser <= item.start;
         req_tlast <= item.last;
         do @(posedge clock); while (!req_tready);
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic finish_phase();
      @(posedge clock);
      while (sb.pending_headers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      logic [31:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= {16'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_limit(value);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback != {16'h0, value})
         sb.report("search_limit read back", 64'(readback), 64'({16'h0, value}));
   endtask

   // receiver: changing stall patterns plus one long hold-off on request
   initial begin
      stall_mode_type mode;
      int             seg_left;
      int             hold_left;
      int             tick;
      mode = READY_ALWAYS;
      seg_left = 0;
      hold_left = 0;
      tick = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 2));
               seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (mode)
               READY_ALWAYS:        rsp_tready <= 1'b1;
               READY_THREE_OF_FOUR: rsp_tready <= (tick % 4 != 0);
               default:             rsp_tready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready) sb.take_byte(req_tdata, req_tuser, req_tlast);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no transfer for %0d cycles", QUIET_LIMIT);
         $display("wav_header_parser_test NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [15:0] limit_value;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      req_tlast <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      send_all();
      finish_phase();
      for (int k = 0; k < 5; k++) begin
         case (k)
            0:       limit_value = 16'hFFFF;
            1:       limit_value = 16'h0000;
            2:       limit_value = 16'($urandom_range(44, 200));
            3:       limit_value = 16'($urandom);
            default: limit_value = 16'($urandom_range(200, 1000));
         endcase
         write_limit(limit_value);
         // receiver holds off while bytes keep coming, so the input backs up
         if (k == 0) hold_rsp_request = 1'b1;
         random_files((k == 0) ? 100 : 30, 1);
         send_all();
         finish_phase();
      end
      if (sb.errors == 0) $display("wav_header_parser_test OK");
      else $display("wav_header_parser_test NOT OK");
      $finish;
   end

endmodule
